@@ rtl/core/sob_pkg.sv @@
package sob_pkg;

	// rounding bias of the byte product
	localparam logic [16:0] ROUND_BIAS = 17'h00080;
	localparam logic [7:0] FULL_ALPHA = 8'hff;

	localparam int DIV_STAGES = 4;
	localparam int BITS_PER_STAGE = 2;
	localparam int FRONT_STAGES = 3;
	localparam int PIPE_DEPTH = FRONT_STAGES + DIV_STAGES;

	// red channel in the lowest bits, alpha in the highest
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgba_t;

	typedef struct packed {
		rgba_t src;
		rgba_t dst;
		logic [7:0] na;
	} mix_t;

	typedef struct packed {
		logic [2:0][15:0] rem;
		logic [2:0][7:0] quo;
		logic [7:0] div;
		logic pass;
		rgba_t dst;
	} div_t;

endpackage

@@ rtl/core/sob_alpha.sv @@
module sob_alpha (
	input  logic clk,
	input  logic en_s1,
	input  logic en_s2,
	input  sob_pkg::rgba_t src,
	input  sob_pkg::rgba_t dst,
	output sob_pkg::mix_t mix_s2
);

	sob_pkg::rgba_t src_s1;
	sob_pkg::rgba_t dst_s1;
	logic [15:0] prod_s1;

	logic [16:0] bias_sum;
	logic [16:0] fold_sum;
	logic [8:0] na_sum;
	logic [7:0] na_next;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			src_s1 <= src;
			dst_s1 <= dst;
			prod_s1 <= (sob_pkg::FULL_ALPHA - dst.alpha) * src.alpha;
		end
	end

	// rounded byte product, then merged alpha clamped to a byte
	always_comb begin
		bias_sum = {1'b0, prod_s1} + sob_pkg::ROUND_BIAS;
		fold_sum = bias_sum + (bias_sum >> 8);
		na_sum = {1'b0, dst_s1.alpha} + {1'b0, fold_sum[15:8]};
		na_next = na_sum[8] ? sob_pkg::FULL_ALPHA : na_sum[7:0];
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			mix_s2.src <= src_s1;
			mix_s2.dst <= dst_s1;
			mix_s2.na <= na_next;
		end
	end

endmodule

@@ rtl/core/sob_weigh.sv @@
module sob_weigh (
	input  logic clk,
	input  logic en_s3,
	input  sob_pkg::mix_t mix,
	output sob_pkg::div_t div_s3
);

	logic [7:0] dw;
	logic [2:0][7:0] s_ch;
	logic [2:0][7:0] d_ch;
	logic [2:0][16:0] acc;

	always_comb begin
		dw = (mix.na >= mix.src.alpha) ? (mix.na - mix.src.alpha) : 8'd0;
		s_ch[0] = mix.src.red;
		s_ch[1] = mix.src.green;
		s_ch[2] = mix.src.blue;
		d_ch[0] = mix.dst.red;
		d_ch[1] = mix.dst.green;
		d_ch[2] = mix.dst.blue;
		for (int c = 0; c < 3; c++) begin
			acc[c] = 17'(s_ch[c] * mix.src.alpha) + 17'(d_ch[c] * dw);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int c = 0; c < 3; c++) begin
				// weighted sum stays below 256 times the merged alpha
				div_s3.rem[c] <= acc[c][15:0];
				div_s3.quo[c] <= 8'd0;
			end
			div_s3.div <= (mix.na != 8'd0) ? mix.na : 8'd1;
			div_s3.pass <= (mix.src.alpha == 8'd0);
			div_s3.dst <= mix.dst;
		end
	end

endmodule

@@ rtl/core/sob_div_step.sv @@
module sob_div_step #(
	parameter int BIT_HI = 7
) (
	input  logic clk,
	input  logic en,
	input  sob_pkg::div_t din,
	output sob_pkg::div_t dout_s
);

	sob_pkg::div_t nxt;
	logic [15:0] cand;

	// restoring division, two quotient bits per stage
	always_comb begin
		nxt = din;
		cand = 16'd0;
		for (int c = 0; c < 3; c++) begin
			for (int b = 0; b < sob_pkg::BITS_PER_STAGE; b++) begin
				cand = 16'({8'd0, din.div} << (BIT_HI - b));
				if (nxt.rem[c] >= cand) begin
					nxt.rem[c] = nxt.rem[c] - cand;
					nxt.quo[c][BIT_HI - b] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout_s <= nxt;
		end
	end

endmodule

@@ rtl/core/straight_alpha_over_blend_core.sv @@
// channel | dir | tdata fields, lowest bit up
// s_*     | in  | src_red, src_green, src_blue, src_a, dst_red, dst_green, dst_blue, dst_alpha
// m_*     | out | out_red, out_green, out_blue, out_alpha
//
// one pixel per cycle while the output is not stalled
// stages: byte product, merged alpha, weighted sums, four divider stages of two bits each
// arst_n clears the valid bits only
// each stage holds while the next one is full and stalled, so bubbles are squeezed out
module straight_alpha_over_blend_core (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [63:0] s_tdata, // src_red, src_green, src_blue, src_a, dst_red, ...
	output logic m_tvalid,
	input  logic m_tready,
	output logic [31:0] m_tdata  // out_red, out_green, out_blue, out_alpha
);

	localparam int DEPTH = sob_pkg::PIPE_DEPTH;

	logic [DEPTH-1:0] vld_q;
	logic [DEPTH-1:0] en;

	sob_pkg::mix_t mix_s2;
	sob_pkg::div_t div_s [sob_pkg::DIV_STAGES+1];
	sob_pkg::div_t last;

	always_comb begin
		en[DEPTH-1] = !vld_q[DEPTH-1] || m_tready;
		for (int k = DEPTH - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < DEPTH; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_tready = en[0];

	sob_alpha u_alpha (
		.clk    (clk),
		.en_s1  (en[0]),
		.en_s2  (en[1]),
		.src    (sob_pkg::rgba_t'(s_tdata[31:0])),
		.dst    (sob_pkg::rgba_t'(s_tdata[63:32])),
		.mix_s2 (mix_s2)
	);

	sob_weigh u_weigh (
		.clk    (clk),
		.en_s3  (en[2]),
		.mix    (mix_s2),
		.div_s3 (div_s[0])
	);

	for (genvar g = 0; g < sob_pkg::DIV_STAGES; g++) begin : g_div
		sob_div_step #(
			.BIT_HI (7 - g * sob_pkg::BITS_PER_STAGE)
		) u_step (
			.clk    (clk),
			.en     (en[sob_pkg::FRONT_STAGES + g]),
			.din    (div_s[g]),
			.dout_s (div_s[g+1])
		);
	end

	assign last = div_s[sob_pkg::DIV_STAGES];

	// transparent source passes the destination through
	assign m_tvalid = vld_q[DEPTH-1];
	assign m_tdata = last.pass ? last.dst : {last.div, last.quo[2], last.quo[1], last.quo[0]};

endmodule

@@ verif/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEMS_PER_PHASE = 330;
	localparam int PRESSURE_ITEMS = 150;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		sob_pkg::rgba_t src;
		sob_pkg::rgba_t dst;
		bit known;
		sob_pkg::rgba_t want;
	} blend_case_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [63:0] s_tdata; // src_red, src_green, src_blue, src_a, dst_red, ...
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata; // out_red, out_green, out_blue, out_alpha

	idle_mode_t idle_mode;
	bit hold_req;
	bit hold_done;
	int unsigned errors;
	int unsigned cycles;
	sob_pkg::rgba_t expected_px[$];
	blend_case_t blend_cases[$];
	sob_pkg::rgba_t got_px;
	sob_pkg::rgba_t want_px;

	straight_alpha_over_blend_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic sob_pkg::rgba_t px(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic [7:0] a);
		return {a, b, g, r};
	endfunction

	function automatic logic [7:0] weigh_channel(input int unsigned s, input int unsigned d,
		input int unsigned sa, input int unsigned na);
		int unsigned dw;
		int unsigned v;
		dw = (na >= sa) ? na - sa : 0;
		v = (s * sa + d * dw) / ((na != 0) ? na : 1);
		return (v > 255) ? 8'hff : v[7:0];
	endfunction

	function automatic sob_pkg::rgba_t blend_pixel(input sob_pkg::rgba_t src,
		input sob_pkg::rgba_t dst);
		int unsigned prod;
		int unsigned na;
		sob_pkg::rgba_t res;
		if (src.alpha == 8'h00)
			return dst;
		// rounded byte product of the uncovered share
		prod = (255 - int'(dst.alpha)) * int'(src.alpha) + 128;
		na = int'(dst.alpha) + ((prod + (prod >> 8)) >> 8);
		if (na > 255)
			na = 255;
		res.red = weigh_channel(src.red, dst.red, src.alpha, na);
		res.green = weigh_channel(src.green, dst.green, src.alpha, na);
		res.blue = weigh_channel(src.blue, dst.blue, src.alpha, na);
		res.alpha = na[7:0];
		return res;
	endfunction

	function automatic bit roll_idle(input bit sender_side);
		int pct;
		pct = 0;
		case (idle_mode)
			IDLE_SENDER: begin
				if (sender_side)
					pct = 79;
			end
			IDLE_RECEIVER: begin
				if (!sender_side)
					pct = 79;
			end
			IDLE_BOTH: pct = 34;
			default: pct = 0;
		endcase
		return $urandom_range(99) < pct;
	endfunction

	task automatic add_case(input sob_pkg::rgba_t src, input sob_pkg::rgba_t dst,
		input bit known, input sob_pkg::rgba_t want);
		blend_case_t c;
		c.src = src;
		c.dst = dst;
		c.known = known;
		c.want = want;
		blend_cases.push_back(c);
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_pixel(input sob_pkg::rgba_t src, input sob_pkg::rgba_t dst,
		input bit known, input sob_pkg::rgba_t want);
		while (roll_idle(1'b1)) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {dst, src};
		do
			@(posedge clk);
		while (!s_tready);
		expected_px.push_back(known ? want : blend_pixel(src, dst));
		@(negedge clk);
	endtask

	task automatic send_random_pixel();
		sob_pkg::rgba_t src;
		sob_pkg::rgba_t dst;
		src = $urandom;
		dst = $urandom;
		// lean on the alpha corners
		case ($urandom_range(7))
			0: src.alpha = 8'h00;
			1: src.alpha = sob_pkg::FULL_ALPHA;
			2: dst.alpha = 8'h00;
			3: dst.alpha = sob_pkg::FULL_ALPHA;
			4: src.alpha = 8'($urandom_range(3, 1));
			default: ;
		endcase
		send_pixel(src, dst, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_px = m_tdata;
			if (expected_px.size() == 0) begin
				report_mismatch("spurious pixel", m_tdata, 0);
			end else begin
				want_px = expected_px.pop_front();
				if (got_px.red !== want_px.red)
					report_mismatch("out_red", got_px.red, want_px.red);
				if (got_px.green !== want_px.green)
					report_mismatch("out_green", got_px.green, want_px.green);
				if (got_px.blue !== want_px.blue)
					report_mismatch("out_blue", got_px.blue, want_px.blue);
				if (got_px.alpha !== want_px.alpha)
					report_mismatch("out_alpha", got_px.alpha, want_px.alpha);
			end
		end
	end

	// receiver side, with one long hold-off on demand
	initial begin
		m_tready = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				m_tready <= !roll_idle(1'b0);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		idle_mode = IDLE_NONE;
		hold_req = 1'b0;
		errors = 0;
		cycles = 0;

		// transparent source passes the destination
		add_case(px(8'h12, 8'h34, 8'h56, 8'h00), px(8'h9a, 8'hbc, 8'hde, 8'h77), 1'b1,
			px(8'h9a, 8'hbc, 8'hde, 8'h77));
		add_case(px(8'hff, 8'hff, 8'hff, 8'h00), px(8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
			px(8'h00, 8'h00, 8'h00, 8'h00));
		add_case(px(8'h00, 8'h00, 8'h00, 8'h00), px(8'hff, 8'hff, 8'hff, 8'hff), 1'b1,
			px(8'hff, 8'hff, 8'hff, 8'hff));
		// opaque source replaces the colour
		add_case(px(8'hff, 8'h80, 8'h01, 8'hff), px(8'h00, 8'h7f, 8'hfe, 8'h00), 1'b1,
			px(8'hff, 8'h80, 8'h01, 8'hff));
		add_case(px(8'h00, 8'h00, 8'h00, 8'hff), px(8'hff, 8'hff, 8'hff, 8'hff), 1'b1,
			px(8'h00, 8'h00, 8'h00, 8'hff));
		add_case(px(8'hff, 8'hff, 8'hff, 8'hff), px(8'h00, 8'h00, 8'h00, 8'h80), 1'b1,
			px(8'hff, 8'hff, 8'hff, 8'hff));
		add_case(px(8'h55, 8'haa, 8'h0f, 8'hff), px(8'hf0, 8'h33, 8'hcc, 8'h01), 1'b1,
			px(8'h55, 8'haa, 8'h0f, 8'hff));
		// partial coverage
		add_case(px(8'hff, 8'hff, 8'hff, 8'h01), px(8'h00, 8'h00, 8'h00, 8'h00), 1'b0, '0);
		add_case(px(8'hff, 8'h00, 8'h80, 8'h01), px(8'h00, 8'hff, 8'h80, 8'hff), 1'b0, '0);
		add_case(px(8'hff, 8'h00, 8'hff, 8'h01), px(8'h00, 8'hff, 8'h00, 8'hfe), 1'b0, '0);
		add_case(px(8'h00, 8'hff, 8'h7f, 8'hfe), px(8'hff, 8'h00, 8'h80, 8'h00), 1'b0, '0);
		add_case(px(8'h00, 8'hff, 8'h7f, 8'hfe), px(8'hff, 8'h00, 8'h80, 8'hfe), 1'b0, '0);
		add_case(px(8'hc8, 8'h64, 8'h32, 8'h80), px(8'h10, 8'h20, 8'h30, 8'h80), 1'b0, '0);
		add_case(px(8'hff, 8'hff, 8'hff, 8'h80), px(8'h00, 8'h00, 8'h00, 8'h00), 1'b0, '0);
		add_case(px(8'hff, 8'hff, 8'hff, 8'h7f), px(8'h00, 8'h00, 8'h00, 8'h01), 1'b0, '0);
		add_case(px(8'h01, 8'hfe, 8'h80, 8'h02), px(8'hfe, 8'h01, 8'h7f, 8'hfd), 1'b0, '0);
		add_case(px(8'hff, 8'hff, 8'hff, 8'hfe), px(8'hff, 8'hff, 8'hff, 8'hff), 1'b0, '0);
		add_case(px(8'h00, 8'h00, 8'h00, 8'h01), px(8'hff, 8'hff, 8'hff, 8'h01), 1'b0, '0);

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (blend_cases[i])
			send_pixel(blend_cases[i].src, blend_cases[i].dst, blend_cases[i].known,
				blend_cases[i].want);

		for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
			idle_mode = idle_mode_t'(m);
			repeat (ITEMS_PER_PHASE) send_random_pixel();
		end

		// sender keeps requesting while the receiver holds off
		idle_mode = IDLE_NONE;
		hold_req = 1'b1;
		repeat (PRESSURE_ITEMS) send_random_pixel();
		s_tvalid <= 1'b0;

		while (expected_px.size() != 0)
			@(posedge clk);
		repeat (sob_pkg::PIPE_DEPTH * 4) @(posedge clk);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/sob_pkg.sv
rtl/core/sob_alpha.sv
rtl/core/sob_weigh.sv
rtl/core/sob_div_step.sv
rtl/core/straight_alpha_over_blend_core.sv
verif/testbench.sv
